@@ src/bir_pkg.sv @@
// Shared widths and codes for the bilinear image resize block.
package bir_pkg;

  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int CH_W       = 2;
  localparam int SMP_W      = 8;
  localparam int RATIO_W    = 25;
  localparam int FRAC_W     = 16;
  localparam int POS_W      = RATIO_W + COL_W;
  localparam int IDX_W      = POS_W - FRAC_W;
  localparam int IN_DIM_W   = 9;
  localparam int OUT_DIM_W  = 11;
  localparam int NCH_CFG_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int WGT_W      = FRAC_W + 1;
  localparam int TOP_W      = WGT_W + SMP_W;
  localparam int SUM_W      = WGT_W + TOP_W;

  localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1 << FRAC_W);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_REQ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_RATIO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_RATIO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS     = 3'd6;

  typedef logic [SMP_W-1:0] sample_t;

endpackage

@@ src/bilinear_image_resize_top.sv @@
// Bilinear image resize: frame store, coordinate mapping and blend pipeline.
//
// Loads (cmd 0) write one source sample into a frame store split into four
// banks by row and column parity; requests (cmd 1) map the output position
// through the Q9.16 ratios, read all four neighbours from the banks at once
// and blend them, returning one result per request and none per load.
// One item is taken every clock while in_ready is high; a request's result
// passes through the stage registers to the output register. A stall on the
// output fills the six-stage pipeline before the input is held. Requests on
// the output border or for a channel beyond the configured count return
// zero; neighbours past the last source row or column are clamped to it.
// Registers must be written only while the block is idle; the block does
// not enforce this. Reading a sample never loaded returns an undefined value.
module bilinear_image_resize_top #(
  parameter int MAX_IN_WIDTH  = 256,
  parameter int MAX_IN_HEIGHT = 256,
  parameter int MAX_CHANNELS  = 3,
  parameter int MAX_OUT_DIM   = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bir_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [bir_pkg::ROW_W-1:0]      in_row,
  input  logic [bir_pkg::COL_W-1:0]      in_col,
  input  logic [bir_pkg::CH_W-1:0]       in_channel,
  input  bir_pkg::sample_t               in_sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bir_pkg::sample_t               out_sample_out,
  output logic [bir_pkg::ROW_W-1:0]      out_row,
  output logic [bir_pkg::COL_W-1:0]      out_col,
  output logic [bir_pkg::CH_W-1:0]       out_channel
);
  import bir_pkg::*;

  localparam int XW         = (MAX_IN_WIDTH > 2) ? $clog2(MAX_IN_WIDTH) : 1;
  localparam int YW         = (MAX_IN_HEIGHT > 2) ? $clog2(MAX_IN_HEIGHT) : 1;
  localparam int OW         = $clog2(MAX_OUT_DIM + 1);
  localparam int NCW        = $clog2(MAX_CHANNELS + 1);
  localparam int HALF_W     = (MAX_IN_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_IN_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H * MAX_CHANNELS;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // configuration registers
  logic [IN_DIM_W-1:0]   in_width_r, in_height_r;
  logic [OUT_DIM_W-1:0]  out_width_r, out_height_r;
  logic [RATIO_W-1:0]    width_ratio_r, height_ratio_r;
  logic [NCH_CFG_W-1:0]  channels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r     <= IN_DIM_W'(256);
      in_height_r    <= IN_DIM_W'(256);
      out_width_r    <= OUT_DIM_W'(256);
      out_height_r   <= OUT_DIM_W'(256);
      width_ratio_r  <= RATIO_W'(65536);
      height_ratio_r <= RATIO_W'(65536);
      channels_r     <= NCH_CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_WIDTH:     in_width_r     <= cfg_data[IN_DIM_W-1:0];
        CFG_IN_HEIGHT:    in_height_r    <= cfg_data[IN_DIM_W-1:0];
        CFG_OUT_WIDTH:    out_width_r    <= cfg_data[OUT_DIM_W-1:0];
        CFG_OUT_HEIGHT:   out_height_r   <= cfg_data[OUT_DIM_W-1:0];
        CFG_WIDTH_RATIO:  width_ratio_r  <= cfg_data[RATIO_W-1:0];
        CFG_HEIGHT_RATIO: height_ratio_r <= cfg_data[RATIO_W-1:0];
        CFG_CHANNELS:     channels_r     <= cfg_data[NCH_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated register values
  logic [XW-1:0]  iw_m1;
  logic [YW-1:0]  ih_m1;
  logic [OW-1:0]  ow_e, oh_e;
  logic [NCW-1:0] nch_e;

  always_comb begin
    if (in_width_r == '0) iw_m1 = '0;
    else if (32'(in_width_r) > MAX_IN_WIDTH) iw_m1 = XW'(MAX_IN_WIDTH - 1);
    else iw_m1 = XW'(in_width_r - IN_DIM_W'(1));
    if (in_height_r == '0) ih_m1 = '0;
    else if (32'(in_height_r) > MAX_IN_HEIGHT) ih_m1 = YW'(MAX_IN_HEIGHT - 1);
    else ih_m1 = YW'(in_height_r - IN_DIM_W'(1));
    ow_e = (32'(out_width_r) > MAX_OUT_DIM) ? OW'(MAX_OUT_DIM) : OW'(out_width_r);
    oh_e = (32'(out_height_r) > MAX_OUT_DIM) ? OW'(MAX_OUT_DIM) : OW'(out_height_r);
    if (channels_r == '0) nch_e = NCW'(1);
    else if (32'(channels_r) > MAX_CHANNELS) nch_e = NCW'(MAX_CHANNELS);
    else nch_e = NCW'(channels_r);
  end

  // stage enables
  logic en1, en2, en3, en4, en5, en6;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic cmd4_r;

  assign en6      = !v6_r || out_ready;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r && (cmd4_r == CMD_REQ);
      if (en6) v6_r <= v5_r;
    end
  end

  // stage 1: range checks and source position
  logic                 cmd1_r, ok1_r;
  logic [ROW_W-1:0]     row1_r;
  logic [COL_W-1:0]     col1_r;
  logic [CH_W-1:0]      ch1_r;
  sample_t              smp1_r;
  logic [POS_W-1:0]     xpos1_r, ypos1_r;
  logic                 ok1_nxt;

  always_comb begin
    if (in_cmd == CMD_LOAD)
      ok1_nxt = (32'(in_row) <= 32'(ih_m1)) && (32'(in_col) <= 32'(iw_m1))
                && (32'(in_channel) < 32'(nch_e));
    else
      ok1_nxt = (in_row != '0) && (in_col != '0)
                && (32'(in_row) + 32'd1 < 32'(oh_e))
                && (32'(in_col) + 32'd1 < 32'(ow_e))
                && (32'(in_channel) < 32'(nch_e));
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1_r  <= in_cmd;
      ok1_r   <= ok1_nxt;
      row1_r  <= in_row;
      col1_r  <= in_col;
      ch1_r   <= in_channel;
      smp1_r  <= in_sample_in;
      xpos1_r <= POS_W'(width_ratio_r) * POS_W'(in_col);
      ypos1_r <= POS_W'(height_ratio_r) * POS_W'(in_row);
    end
  end

  // stage 2: neighbour clamp
  logic                 cmd2_r, ok2_r;
  logic [ROW_W-1:0]     row2_r;
  logic [COL_W-1:0]     col2_r;
  logic [CH_W-1:0]      ch2_r;
  sample_t              smp2_r;
  logic [FRAC_W-1:0]    a2_r, b2_r;
  logic [XW-1:0]        c0_2_r, c1_2_r, c0_nxt, c1_nxt;
  logic [YW-1:0]        r0_2_r, r1_2_r, r0_nxt, r1_nxt;
  logic [IDX_W-1:0]     xi, yi;

  always_comb begin
    xi = xpos1_r[POS_W-1:FRAC_W];
    yi = ypos1_r[POS_W-1:FRAC_W];
    if (cmd1_r == CMD_LOAD) begin
      r0_nxt = YW'(row1_r);
      r1_nxt = YW'(row1_r);
      c0_nxt = XW'(col1_r);
      c1_nxt = XW'(col1_r);
    end else begin
      r0_nxt = (32'(yi) < 32'(ih_m1)) ? YW'(yi) : ih_m1;
      r1_nxt = (32'(yi) + 32'd1 < 32'(ih_m1)) ? YW'(32'(yi) + 32'd1) : ih_m1;
      c0_nxt = (32'(xi) < 32'(iw_m1)) ? XW'(xi) : iw_m1;
      c1_nxt = (32'(xi) + 32'd1 < 32'(iw_m1)) ? XW'(32'(xi) + 32'd1) : iw_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      cmd2_r <= cmd1_r;
      ok2_r  <= ok1_r;
      row2_r <= row1_r;
      col2_r <= col1_r;
      ch2_r  <= ch1_r;
      smp2_r <= smp1_r;
      a2_r   <= xpos1_r[FRAC_W-1:0];
      b2_r   <= ypos1_r[FRAC_W-1:0];
      r0_2_r <= r0_nxt;
      r1_2_r <= r1_nxt;
      c0_2_r <= c0_nxt;
      c1_2_r <= c1_nxt;
    end
  end

  // stage 3: bank addresses
  logic                 cmd3_r, ok3_r;
  logic [ROW_W-1:0]     row3_r;
  logic [COL_W-1:0]     col3_r;
  logic [CH_W-1:0]      ch3_r;
  sample_t              smp3_r;
  logic [FRAC_W-1:0]    a3_r, b3_r;
  logic                 r0p3_r, r1p3_r, c0p3_r, c1p3_r;
  logic [BA_W-1:0]      addr3_r [4];
  logic [BA_W-1:0]      addr_nxt [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [YW-1:0] rs;
      logic [XW-1:0] cs;
      rs = (r0_2_r[0] == k[1]) ? r0_2_r : r1_2_r;
      cs = (c0_2_r[0] == k[0]) ? c0_2_r : c1_2_r;
      addr_nxt[k] = BA_W'((32'(rs >> 1) * HALF_W + 32'(cs >> 1)) * MAX_CHANNELS
                          + 32'(ch2_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      cmd3_r  <= cmd2_r;
      ok3_r   <= ok2_r;
      row3_r  <= row2_r;
      col3_r  <= col2_r;
      ch3_r   <= ch2_r;
      smp3_r  <= smp2_r;
      a3_r    <= a2_r;
      b3_r    <= b2_r;
      r0p3_r  <= r0_2_r[0];
      r1p3_r  <= r1_2_r[0];
      c0p3_r  <= c0_2_r[0];
      c1p3_r  <= c1_2_r[0];
      addr3_r <= addr_nxt;
    end
  end

  // stage 4: parity-banked frame store
  logic                 ok4_r;
  logic [ROW_W-1:0]     row4_r;
  logic [COL_W-1:0]     col4_r;
  logic [CH_W-1:0]      ch4_r;
  logic [FRAC_W-1:0]    a4_r, b4_r;
  logic                 r0p4_r, r1p4_r, c0p4_r, c1p4_r;
  sample_t              rd4_r [4];
  logic                 wr_ok;

  assign wr_ok = en4 && v3_r && (cmd3_r == CMD_LOAD) && ok3_r;

  for (genvar gi = 0; gi < 4; gi++) begin : g_bank
    localparam logic BR = (gi >= 2);
    localparam logic BC = (gi % 2 == 1);
    sample_t mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (wr_ok && r0p3_r == BR && c0p3_r == BC) mem[addr3_r[gi]] <= smp3_r;
      if (en4) rd4_r[gi] <= mem[addr3_r[gi]];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      cmd4_r <= cmd3_r;
      ok4_r  <= ok3_r;
      row4_r <= row3_r;
      col4_r <= col3_r;
      ch4_r  <= ch3_r;
      a4_r   <= a3_r;
      b4_r   <= b3_r;
      r0p4_r <= r0p3_r;
      r1p4_r <= r1p3_r;
      c0p4_r <= c0p3_r;
      c1p4_r <= c1p3_r;
    end
  end

  // stage 5: horizontal blend
  logic                 ok5_r;
  logic [ROW_W-1:0]     row5_r;
  logic [COL_W-1:0]     col5_r;
  logic [CH_W-1:0]      ch5_r;
  logic [FRAC_W-1:0]    b5_r;
  logic [TOP_W-1:0]     top5_r, bot5_r;
  sample_t              tl, tr, bl, br;
  logic [WGT_W-1:0]     wa, a_ext;

  always_comb begin
    tl    = rd4_r[{r0p4_r, c0p4_r}];
    tr    = rd4_r[{r0p4_r, c1p4_r}];
    bl    = rd4_r[{r1p4_r, c0p4_r}];
    br    = rd4_r[{r1p4_r, c1p4_r}];
    a_ext = WGT_W'(a4_r);
    wa    = WGT_ONE - a_ext;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      ok5_r  <= ok4_r;
      row5_r <= row4_r;
      col5_r <= col4_r;
      ch5_r  <= ch4_r;
      b5_r   <= b4_r;
      top5_r <= TOP_W'(wa) * TOP_W'(tl) + TOP_W'(a_ext) * TOP_W'(tr);
      bot5_r <= TOP_W'(wa) * TOP_W'(bl) + TOP_W'(a_ext) * TOP_W'(br);
    end
  end

  // stage 6: vertical blend into the output register
  logic [WGT_W-1:0]     wb, b_ext;
  logic [SUM_W-1:0]     sum;
  sample_t              smp6_r;
  logic [ROW_W-1:0]     row6_r;
  logic [COL_W-1:0]     col6_r;
  logic [CH_W-1:0]      ch6_r;

  always_comb begin
    b_ext = WGT_W'(b5_r);
    wb    = WGT_ONE - b_ext;
    sum   = SUM_W'(wb) * SUM_W'(top5_r) + SUM_W'(b_ext) * SUM_W'(bot5_r);
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      smp6_r <= ok5_r ? sum[2*FRAC_W+SMP_W-1:2*FRAC_W] : '0;
      row6_r <= row5_r;
      col6_r <= col5_r;
      ch6_r  <= ch5_r;
    end
  end

  assign out_valid      = v6_r;
  assign out_sample_out = smp6_r;
  assign out_row        = row6_r;
  assign out_col        = col6_r;
  assign out_channel    = ch6_r;

endmodule

@@ tb/tb_bilinear_image_resize_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the bilinear image resize block.
module tb_bilinear_image_resize_top;
  import bir_pkg::*;

  localparam int MAX_IN_WIDTH    = 256;
  localparam int MAX_IN_HEIGHT   = 256;
  localparam int MAX_CHANNELS    = 3;
  localparam int MAX_OUT_DIM     = 1024;
  localparam int STORE_DEPTH     = MAX_IN_WIDTH * MAX_IN_HEIGHT * MAX_CHANNELS;
  localparam int PIPE_SETTLE     = 12;
  localparam int RX_PARK_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int N_PHASES        = 10;
  localparam int N_EDGE_CFGS     = 4;
  localparam int NO_IDLE_PHASE   = 5;
  localparam int PARK_PHASE      = 7;
  localparam int N_DIR           = 21;
  localparam longint unsigned Q_ONE = 64'd1 << FRAC_W;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [CH_W-1:0]  chan_t;

  typedef struct {
    row_t    row;
    col_t    col;
    chan_t   ch;
    sample_t smp;
  } resize_px_t;

  typedef struct {
    logic    cmd;
    row_t    row;
    col_t    col;
    chan_t   ch;
    sample_t smp;
    bit      fixed;
    sample_t fixed_smp;
  } dir_req_t;

  typedef struct {
    int unsigned in_w, in_h, out_w, out_h, w_ratio, h_ratio, nch;
  } resize_cfg_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_cmd;
  row_t                  in_row;
  col_t                  in_col;
  chan_t                 in_channel;
  sample_t               in_sample_in;
  logic                  out_valid;
  logic                  out_ready;
  sample_t               out_sample_out;
  row_t                  out_row;
  col_t                  out_col;
  chan_t                 out_channel;

  // typed-in expectation travels with the request
  bit      fixed_exp;
  sample_t fixed_smp;

  logic [IN_DIM_W-1:0]  reg_in_width, reg_in_height;
  logic [OUT_DIM_W-1:0] reg_out_width, reg_out_height;
  logic [RATIO_W-1:0]   reg_w_ratio, reg_h_ratio;
  logic [NCH_CFG_W-1:0] reg_channels;

  sample_t    frame_mem    [STORE_DEPTH];
  bit         frame_loaded [STORE_DEPTH];
  resize_px_t pending_px   [$];
  int         fail_count;
  int         stall_cycles;
  bit         no_idle;
  bit         park_rx;

  dir_req_t dir_tbl [N_DIR] = '{
    '{CMD_LOAD, 1, 1, 0, 8'hFF, 0, 0},
    '{CMD_LOAD, 1, 2, 0, 8'hFF, 0, 0},
    '{CMD_LOAD, 2, 1, 0, 8'h00, 0, 0},
    '{CMD_LOAD, 2, 2, 0, 8'h00, 0, 0},
    '{CMD_LOAD, 3, 1, 0, 8'h33, 0, 0},
    '{CMD_LOAD, 3, 2, 0, 8'h77, 0, 0},
    '{CMD_LOAD, 254, 254, 0, 8'h10, 0, 0},
    '{CMD_LOAD, 254, 255, 0, 8'h20, 0, 0},
    '{CMD_LOAD, 255, 254, 0, 8'h40, 0, 0},
    '{CMD_LOAD, 255, 255, 0, 8'h80, 0, 0},
    '{CMD_LOAD, 1023, 1023, 3, 8'hFF, 0, 0},
    '{CMD_LOAD, 1, 1, 1, 8'h55, 0, 0},
    '{CMD_REQ, 0, 0, 0, 8'h00, 1, 8'h00},
    '{CMD_REQ, 1, 1, 0, 8'hAA, 1, 8'hFF},
    '{CMD_REQ, 254, 254, 0, 8'h00, 0, 0},
    '{CMD_REQ, 255, 1, 0, 8'h00, 1, 8'h00},
    '{CMD_REQ, 1, 255, 0, 8'h00, 1, 8'h00},
    '{CMD_REQ, 1023, 1023, 3, 8'hFF, 1, 8'h00},
    '{CMD_REQ, 1, 1, 1, 8'h00, 1, 8'h00},
    '{CMD_REQ, 1, 1, 3, 8'h00, 1, 8'h00},
    '{CMD_REQ, 2, 1, 0, 8'h00, 0, 0}
  };

  resize_cfg_t edge_cfgs [N_EDGE_CFGS] = '{
    '{2, 2, 1024, 1024, 0, 0, 3},
    '{256, 256, 3, 3, 16777216, 16777216, 3},
    '{0, 511, 2047, 1500, 33554431, 33554431, 0},
    '{16, 16, 1, 1, 65536, 65536, 2}
  };

  bilinear_image_resize_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_channel    (in_channel),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_channel   (out_channel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned store_idx(int unsigned r, int unsigned c, int unsigned ch);
    return (r * MAX_IN_WIDTH + c) * MAX_CHANNELS + ch;
  endfunction

  // non-border request for a configured channel
  function automatic bit px_active(row_t r, col_t c, chan_t ch);
    int unsigned ow, oh, nch;
    ow  = sat(reg_out_width, 0, MAX_OUT_DIM);
    oh  = sat(reg_out_height, 0, MAX_OUT_DIM);
    nch = sat(reg_channels, 1, MAX_CHANNELS);
    return (r != 0) && (c != 0) && (int'(r) + 1 < oh) && (int'(c) + 1 < ow) && (ch < nch);
  endfunction

  function automatic void src_corners(input row_t r, input col_t c,
                                      output int unsigned r0, r1, c0, c1,
                                      output longint unsigned a, b);
    longint unsigned ypos, xpos, yi, xi;
    int unsigned     ih, iw;
    ih   = sat(reg_in_height, 1, MAX_IN_HEIGHT);
    iw   = sat(reg_in_width, 1, MAX_IN_WIDTH);
    ypos = reg_h_ratio;
    ypos = ypos * r;
    xpos = reg_w_ratio;
    xpos = xpos * c;
    yi   = ypos >> FRAC_W;
    xi   = xpos >> FRAC_W;
    b    = ypos & (Q_ONE - 1);
    a    = xpos & (Q_ONE - 1);
    r0   = (yi < ih - 1) ? 32'(yi) : ih - 1;
    r1   = (yi + 1 < ih - 1) ? 32'(yi + 1) : ih - 1;
    c0   = (xi < iw - 1) ? 32'(xi) : iw - 1;
    c1   = (xi + 1 < iw - 1) ? 32'(xi + 1) : iw - 1;
  endfunction

  function automatic sample_t blend_sample(row_t r, col_t c, chan_t ch);
    int unsigned     r0, r1, c0, c1;
    longint unsigned a, b, tl, tr, bl, br, top, bot, sum;
    if (!px_active(r, c, ch)) return '0;
    src_corners(r, c, r0, r1, c0, c1, a, b);
    tl  = frame_mem[store_idx(r0, c0, ch)];
    tr  = frame_mem[store_idx(r0, c1, ch)];
    bl  = frame_mem[store_idx(r1, c0, ch)];
    br  = frame_mem[store_idx(r1, c1, ch)];
    top = (Q_ONE - a) * tl + a * tr;
    bot = (Q_ONE - a) * bl + a * br;
    sum = ((Q_ONE - b) * top + b * bot) >> (2 * FRAC_W);
    return (sum > 255) ? 8'hFF : sample_t'(sum);
  endfunction

  // frame store mirror and result checking
  always @(posedge clk) begin : px_check
    resize_px_t want;
    int unsigned idx;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (in_cmd == CMD_LOAD) begin
          if (in_row < sat(reg_in_height, 1, MAX_IN_HEIGHT) &&
              in_col < sat(reg_in_width, 1, MAX_IN_WIDTH) &&
              in_channel < sat(reg_channels, 1, MAX_CHANNELS)) begin
            idx = store_idx(in_row, in_col, in_channel);
            frame_mem[idx]    = in_sample_in;
            frame_loaded[idx] = 1'b1;
          end
        end else begin
          want.row = in_row;
          want.col = in_col;
          want.ch  = in_channel;
          want.smp = fixed_exp ? fixed_smp : blend_sample(in_row, in_col, in_channel);
          pending_px.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_px.size() == 0) begin
          $error("result with no pending request: row %0d col %0d", out_row, out_col);
          fail_count++;
        end else begin
          want = pending_px.pop_front();
          if (want.smp !== out_sample_out) begin
            $error("sample_out: expected %0d, got %0d", want.smp, out_sample_out);
            fail_count++;
          end
          if (want.row !== out_row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_row);
            fail_count++;
          end
          if (want.col !== out_col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_col);
            fail_count++;
          end
          if (want.ch !== out_channel) begin
            $error("out_channel: expected %0d, got %0d", want.ch, out_channel);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    bit park_done;
    park_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (park_rx && !park_done) begin
        park_done = 1'b1;
        out_ready <= 1'b0;
        repeat (RX_PARK_CYCLES) @(negedge clk);
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= 29);
    end
  end

  // starts and ends at a falling edge; valid stays high until the next call
  task automatic send_item(logic cmd, row_t r, col_t c, chan_t ch, sample_t v,
                           bit fixed = 1'b0, sample_t fsmp = '0);
    if (!no_idle && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_row       <= r;
    in_col       <= c;
    in_channel   <= ch;
    in_sample_in <= v;
    fixed_exp    <= fixed;
    fixed_smp    <= fsmp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(v);
    @(negedge clk);
    case (idx)
      CFG_IN_WIDTH:     reg_in_width   = IN_DIM_W'(v);
      CFG_IN_HEIGHT:    reg_in_height  = IN_DIM_W'(v);
      CFG_OUT_WIDTH:    reg_out_width  = OUT_DIM_W'(v);
      CFG_OUT_HEIGHT:   reg_out_height = OUT_DIM_W'(v);
      CFG_WIDTH_RATIO:  reg_w_ratio    = RATIO_W'(v);
      CFG_HEIGHT_RATIO: reg_h_ratio    = RATIO_W'(v);
      CFG_CHANNELS:     reg_channels   = NCH_CFG_W'(v);
      default: ;
    endcase
  endtask

  task automatic apply_cfg(resize_cfg_t k);
    cfg_write(CFG_IN_WIDTH, k.in_w);
    cfg_write(CFG_IN_HEIGHT, k.in_h);
    cfg_write(CFG_OUT_WIDTH, k.out_w);
    cfg_write(CFG_OUT_HEIGHT, k.out_h);
    cfg_write(CFG_WIDTH_RATIO, k.w_ratio);
    cfg_write(CFG_HEIGHT_RATIO, k.h_ratio);
    cfg_write(CFG_CHANNELS, k.nch);
    cfg_write(CFG_UNUSED, $urandom);
    cfg_we <= 1'b0;
  endtask

  function automatic resize_cfg_t random_cfg();
    resize_cfg_t k;
    k.in_w  = ($urandom_range(0, 99) < 70) ? $urandom_range(2, 16) : $urandom_range(2, 256);
    k.in_h  = ($urandom_range(0, 99) < 70) ? $urandom_range(2, 16) : $urandom_range(2, 256);
    k.out_w = ($urandom_range(0, 99) < 80) ? $urandom_range(3, 64) : $urandom_range(1, 1024);
    k.out_h = ($urandom_range(0, 99) < 80) ? $urandom_range(3, 64) : $urandom_range(1, 1024);
    k.w_ratio = ($urandom_range(0, 99) < 75) ? (k.in_w << FRAC_W) / k.out_w
                                             : $urandom_range(0, (1 << RATIO_W) - 1);
    k.h_ratio = ($urandom_range(0, 99) < 75) ? (k.in_h << FRAC_W) / k.out_h
                                             : $urandom_range(0, (1 << RATIO_W) - 1);
    k.nch   = $urandom_range(0, 3);
    return k;
  endfunction

  // load a neighbor that a request is about to read, if never written
  task automatic fill_sample(int unsigned r, int unsigned c, chan_t ch, inout int cnt);
    if (!frame_loaded[store_idx(r, c, ch)]) begin
      send_item(CMD_LOAD, row_t'(r), col_t'(c), ch, sample_t'($urandom_range(0, 255)));
      cnt++;
    end
  endtask

  task automatic run_phase(int n_items);
    int              done, roll;
    int unsigned     ih, iw, nch, oh, ow, r0, r1, c0, c1;
    longint unsigned a, b;
    row_t            r;
    col_t            c;
    chan_t           ch;
    ih   = sat(reg_in_height, 1, MAX_IN_HEIGHT);
    iw   = sat(reg_in_width, 1, MAX_IN_WIDTH);
    nch  = sat(reg_channels, 1, MAX_CHANNELS);
    oh   = sat(reg_out_height, 0, MAX_OUT_DIM);
    ow   = sat(reg_out_width, 0, MAX_OUT_DIM);
    done = 0;
    while (done < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        // mostly off the frame
        r  = row_t'($urandom_range(0, 1023));
        c  = col_t'($urandom_range(0, 1023));
        ch = chan_t'($urandom_range(0, 3));
        send_item(CMD_LOAD, r, c, ch, sample_t'($urandom_range(0, 255)));
        if (r < ih && c < iw && ch < nch) done++;
      end else if (roll < 40) begin
        r  = row_t'($urandom_range(0, ih - 1));
        c  = col_t'($urandom_range(0, iw - 1));
        ch = chan_t'($urandom_range(0, nch - 1));
        send_item(CMD_LOAD, r, c, ch, sample_t'($urandom_range(0, 255)));
        done++;
      end else begin
        r  = row_t'((oh >= 3 && $urandom_range(0, 99) < 85) ? $urandom_range(1, oh - 2)
                                                            : $urandom_range(0, 1023));
        c  = col_t'((ow >= 3 && $urandom_range(0, 99) < 85) ? $urandom_range(1, ow - 2)
                                                            : $urandom_range(0, 1023));
        ch = chan_t'(($urandom_range(0, 99) < 85) ? $urandom_range(0, nch - 1)
                                                  : $urandom_range(0, 3));
        if (px_active(r, c, ch)) begin
          src_corners(r, c, r0, r1, c0, c1, a, b);
          fill_sample(r0, c0, ch, done);
          fill_sample(r0, c1, ch, done);
          fill_sample(r1, c0, ch, done);
          fill_sample(r1, c1, ch, done);
        end
        send_item(CMD_REQ, r, c, ch, sample_t'($urandom_range(0, 255)));
        done++;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_cmd         = CMD_LOAD;
    in_row         = '0;
    in_col         = '0;
    in_channel     = '0;
    in_sample_in   = '0;
    fixed_exp      = 1'b0;
    fixed_smp      = '0;
    no_idle        = 1'b0;
    park_rx        = 1'b0;
    reg_in_width   = 256;
    reg_in_height  = 256;
    reg_out_width  = 256;
    reg_out_height = 256;
    reg_w_ratio    = 65536;
    reg_h_ratio    = 65536;
    reg_channels   = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tbl[i])
      send_item(dir_tbl[i].cmd, dir_tbl[i].row, dir_tbl[i].col, dir_tbl[i].ch,
                dir_tbl[i].smp, dir_tbl[i].fixed, dir_tbl[i].fixed_smp);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      apply_cfg((p < N_EDGE_CFGS) ? edge_cfgs[p] : random_cfg());
      no_idle = (p == NO_IDLE_PHASE);
      if (p == PARK_PHASE) park_rx = 1'b1;
      run_phase(ITEMS_PER_PHASE);
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/bir_pkg.sv
src/bilinear_image_resize_top.sv
tb/tb_bilinear_image_resize_top.sv
